// ===== rtl/gdo_pkg.sv =====
// ============================================================================
// gdo_pkg
// Shared types and constants for the Gregorian date to day offset pipeline.
// ============================================================================
package gdo_pkg;

    // Year of the epoch; day offset zero is 1 January of this year.
    localparam int EPOCH_YEAR  = 1960;
    localparam int EPOCH_PRIOR = EPOCH_YEAR - 1;

    // Day count of the epoch in the pipeline's numbering, where a count of
    // one is 1 January of year 0 and a count of zero is the day before it.
    localparam int EPOCH_COUNT = 365 * EPOCH_YEAR + EPOCH_PRIOR / 4
                               - EPOCH_PRIOR / 100 + EPOCH_PRIOR / 400 + 2;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int OFFSET_W = 23;
    localparam int WDAY_W   = 3;
    localparam int COUNT_W  = 22;
    localparam int PART_W   = 9;
    localparam int Q100_W   = 8;
    localparam int Q7_W     = 20;

    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;

    // Division by 100 for values below 2**14: (x * 5243) >> 19.
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam int          DIV100_PW    = YEAR_W + 13;

    // Division by 7 for values below 2**22: (x * 4793491) >> 25.
    localparam logic [22:0] DIV7_MUL   = 23'd4793491;
    localparam int          DIV7_SHIFT = 25;
    localparam int          DIV7_PW    = COUNT_W + 23;

    // Day 1 of year 0 is a Saturday (5); shifting the count by four makes
    // the remainder modulo 7 equal the weekday directly.
    localparam logic [COUNT_W-1:0] WDAY_BIAS = 22'd4;

    typedef struct packed {
        logic [DAY_W-1:0]   day_of_month;
        logic [MONTH_W-1:0] month_number;
        logic [YEAR_W-1:0]  year_number;
    } date_t;

    typedef struct packed {
        logic signed [OFFSET_W-1:0] day_offset;
        logic [WDAY_W-1:0]          weekday;
    } result_t;

    // Output of the day counting front end.
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] day_count;
    } count_t;

    // Days in the months before the given month of a common year.
    function automatic logic [PART_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [PART_W-1:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/gdo_day_count.sv =====
// ============================================================================
// gdo_day_count
// Three-stage front end: turns a date into a linear day count from year 0.
// ============================================================================
module gdo_day_count
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            date_valid,
    output logic            date_stall,
    input  gdo_pkg::date_t  date,
    input  logic            count_ready,
    output gdo_pkg::count_t count
);

    // Stage 1: clamped fields and quotients by 100.
    logic                        v1_reg;
    logic [gdo_pkg::YEAR_W-1:0]  year1_reg;
    logic [gdo_pkg::MONTH_W-1:0] month1_reg;
    logic [gdo_pkg::DAY_W-1:0]   day1_reg;
    logic [gdo_pkg::Q100_W-1:0]  qprior1_reg;
    logic [gdo_pkg::Q100_W-1:0]  qyear1_reg;

    // Stage 2: days before the year and the part within the year.
    logic                        v2_reg;
    logic [gdo_pkg::COUNT_W-1:0] ydays2_reg;
    logic [gdo_pkg::PART_W-1:0]  part2_reg;

    // Stage 3: full day count.
    logic                        v3_reg;
    logic [gdo_pkg::COUNT_W-1:0] count3_reg;

    logic ready1, ready2, ready3;

    assign ready3     = !v3_reg || count_ready;
    assign ready2     = !v2_reg || ready3;
    assign ready1     = !v1_reg || ready2;
    assign date_stall = !ready1;

    // ---- stage 1 logic ----
    logic [gdo_pkg::YEAR_W-1:0]      year_clamp;
    logic [gdo_pkg::MONTH_W-1:0]     month_clamp;
    logic [gdo_pkg::YEAR_W-1:0]      prior0;
    logic [gdo_pkg::DIV100_PW-1:0]   prod_prior;
    logic [gdo_pkg::DIV100_PW-1:0]   prod_year;

    always_comb
    begin
        year_clamp = (date.year_number > gdo_pkg::YEAR_MAX) ? gdo_pkg::YEAR_MAX
                                                            : date.year_number;
        if (date.month_number < gdo_pkg::MONTH_JAN)
            month_clamp = gdo_pkg::MONTH_JAN;
        else if (date.month_number > gdo_pkg::MONTH_DEC)
            month_clamp = gdo_pkg::MONTH_DEC;
        else
            month_clamp = date.month_number;
        // Year zero wraps here; stage 2 ignores the quotient in that case.
        prior0     = year_clamp - 14'd1;
        prod_prior = gdo_pkg::DIV100_PW'(prior0) * gdo_pkg::DIV100_PW'(gdo_pkg::DIV100_MUL);
        prod_year  = gdo_pkg::DIV100_PW'(year_clamp)
                   * gdo_pkg::DIV100_PW'(gdo_pkg::DIV100_MUL);
    end

    // ---- stage 2 logic ----
    logic [gdo_pkg::YEAR_W-1:0]  prior1;
    logic [gdo_pkg::COUNT_W-1:0] ydays_next;
    logic [gdo_pkg::Q100_W-1:0]  rem100;
    logic [gdo_pkg::Q100_W-1:0]  hundreds;
    logic                        leap;
    logic [gdo_pkg::PART_W-1:0]  part_next;

    always_comb
    begin
        prior1 = year1_reg - 14'd1;
        if (year1_reg == '0)
            ydays_next = '0;
        else
            ydays_next = gdo_pkg::COUNT_W'(year1_reg) * gdo_pkg::COUNT_W'(365)
                       + gdo_pkg::COUNT_W'(prior1[gdo_pkg::YEAR_W-1:2])
                       - gdo_pkg::COUNT_W'(qprior1_reg)
                       + gdo_pkg::COUNT_W'(qprior1_reg[gdo_pkg::Q100_W-1:2])
                       + gdo_pkg::COUNT_W'(1);
        hundreds = gdo_pkg::Q100_W'(qyear1_reg * 8'd100);
        rem100   = year1_reg[gdo_pkg::Q100_W-1:0] - hundreds;
        // Century years are leap only when divisible by 400.
        if (rem100 == '0)
            leap = (qyear1_reg[1:0] == 2'b00);
        else
            leap = (year1_reg[1:0] == 2'b00);
        part_next = gdo_pkg::days_before_month(month1_reg)
                  + gdo_pkg::PART_W'(day1_reg)
                  + gdo_pkg::PART_W'(leap && (month1_reg > gdo_pkg::MONTH_FEB));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                v1_reg <= date_valid;
            if (ready2)
                v2_reg <= v1_reg;
            if (ready3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && date_valid)
        begin
            year1_reg   <= year_clamp;
            month1_reg  <= month_clamp;
            day1_reg    <= date.day_of_month;
            qprior1_reg <= prod_prior[gdo_pkg::DIV100_SHIFT +: gdo_pkg::Q100_W];
            qyear1_reg  <= prod_year[gdo_pkg::DIV100_SHIFT +: gdo_pkg::Q100_W];
        end
        if (ready2 && v1_reg)
        begin
            ydays2_reg <= ydays_next;
            part2_reg  <= part_next;
        end
        if (ready3 && v2_reg)
            count3_reg <= ydays2_reg + gdo_pkg::COUNT_W'(part2_reg);
    end

    assign count.valid     = v3_reg;
    assign count.day_count = count3_reg;

endmodule

// ===== rtl/gregorian_date_to_day_offset.sv =====
// ============================================================================
// gregorian_date_to_day_offset
// Proleptic Gregorian date to signed day offset from 1 January 1960 plus
// the day of the week.
// ============================================================================
//
//  channel   handshake                   payload   role
//  -------   -------------------------   -------   ------------------------
//  date      date_valid / date_stall     date      date request into block
//  result    result_valid / result_stall result    offset and weekday out
//
// The block is a five-stage pipeline that accepts one request per cycle while
// date_stall is low, and registers each result in its fifth stage. The depth
// is set by the two multiply stages (division by 100 and division by 7) and
// the year-length adder chain between them. Each stage holds its valid bit
// and advances whenever the stage after it is empty or advancing, so bubbles
// close up while the result side stalls. Reset clears the valid bits only.
//
module gregorian_date_to_day_offset
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             date_valid,
    output logic             date_stall,
    input  gdo_pkg::date_t   date,
    output logic             result_valid,
    input  logic             result_stall,
    output gdo_pkg::result_t result
);

    gdo_pkg::count_t count;
    logic            count_ready;

    // Stages 1 to 3: clamp the fields, divide by 100, and form the linear
    // day count in which a count of one is 1 January of year 0.
    gdo_day_count u_day_count
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .date_valid  (date_valid),
        .date_stall  (date_stall),
        .date        (date),
        .count_ready (count_ready),
        .count       (count)
    );

    // Stage 4: offset from the epoch and the quotient of the biased count
    // by 7. Stage 5: the remainder, which is the weekday.
    logic                                v4_reg;
    logic [gdo_pkg::COUNT_W-1:0]         biased4_reg;
    logic [gdo_pkg::Q7_W-1:0]            q7_4_reg;
    logic signed [gdo_pkg::OFFSET_W-1:0] offset4_reg;

    logic                                v5_reg;
    logic signed [gdo_pkg::OFFSET_W-1:0] offset5_reg;
    logic [gdo_pkg::WDAY_W-1:0]          weekday5_reg;

    logic ready4, ready5;

    assign ready5      = !v5_reg || !result_stall;
    assign ready4      = !v4_reg || ready5;
    assign count_ready = ready4;

    logic [gdo_pkg::COUNT_W-1:0]         biased_next;
    logic [gdo_pkg::DIV7_PW-1:0]         prod7;
    logic signed [gdo_pkg::OFFSET_W-1:0] offset_next;
    logic [gdo_pkg::WDAY_W-1:0]          weekday_next;

    always_comb
    begin
        biased_next = count.day_count + gdo_pkg::WDAY_BIAS;
        prod7       = gdo_pkg::DIV7_PW'(biased_next) * gdo_pkg::DIV7_PW'(gdo_pkg::DIV7_MUL);
        // The offset wraps to the output width, as a two's complement value.
        offset_next = signed'(gdo_pkg::OFFSET_W'(count.day_count)
                              - gdo_pkg::OFFSET_W'(gdo_pkg::EPOCH_COUNT));
        // The remainder lies in 0..6, so only its low three bits are needed:
        // x - 7q is congruent to x + q modulo 8.
        weekday_next = biased4_reg[gdo_pkg::WDAY_W-1:0] + q7_4_reg[gdo_pkg::WDAY_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (ready4)
                v4_reg <= count.valid;
            if (ready5)
                v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready4 && count.valid)
        begin
            biased4_reg <= biased_next;
            q7_4_reg    <= prod7[gdo_pkg::DIV7_SHIFT +: gdo_pkg::Q7_W];
            offset4_reg <= offset_next;
        end
        if (ready5 && v4_reg)
        begin
            offset5_reg  <= offset4_reg;
            weekday5_reg <= weekday_next;
        end
    end

    assign result_valid      = v5_reg;
    assign result.day_offset = offset5_reg;
    assign result.weekday    = weekday5_reg;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Checks the Gregorian date to day offset pipeline against an in-bench
// calculation of the day offset and weekday for every accepted request.
// ============================================================================

module tb_top;

    // 1 January of year 0 falls on a Saturday, with 0 meaning Monday.
    localparam int YEAR_ZERO_WEEKDAY = 5;
    localparam int DAYS_PER_WEEK     = 7;
    localparam int MONTH_LAST        = 12;

    // The pipeline is five stages deep; the tail wait covers any straggler.
    localparam int TAIL_CYCLES     = 12;
    // The result side holds off long enough to back the pipeline up fully.
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int HOLD_OFF_DATES  = 40;
    // Cycles in a row with no transfer on either channel before giving up.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PHASE_DATES     = 200;
    localparam int PHASE_COUNT     = 4;

    // Expected offsets and weekdays, oldest first, plus the day arithmetic that
    // produces them. Days past the end of a month simply run on into the next.
    class day_offset_book;
        gdo_pkg::result_t awaited [$];
        int               noted;
        int               checked;
        int               errors;

        // Days from 1 January of year 0 to 1 January of year y.
        function longint days_to_new_year(longint y);
            longint p;
            if (y <= 0)
                return 0;
            p = y - 1;
            return 365 * y + p / 4 - p / 100 + p / 400 + 1;
        endfunction

        function gdo_pkg::result_t predict(gdo_pkg::date_t dt);
            int               cum_days [13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212,
                                                243, 273, 304, 334};
            longint           d;
            longint           m;
            longint           y;
            longint           abs_day;
            longint           offset;
            longint           wd;
            gdo_pkg::result_t r;
            d = longint'(dt.day_of_month);
            m = longint'(dt.month_number);
            y = longint'(dt.year_number);
            // Out-of-range months snap to the nearest real one; the year saturates.
            if (m < gdo_pkg::MONTH_JAN)
                m = gdo_pkg::MONTH_JAN;
            if (m > MONTH_LAST)
                m = MONTH_LAST;
            if (y > gdo_pkg::YEAR_MAX)
                y = gdo_pkg::YEAR_MAX;
            abs_day = days_to_new_year(y) + cum_days[m] + d - 1;
            // Leap day applies on either side of the epoch.
            if (m > gdo_pkg::MONTH_FEB
                && ((y % 400 == 0) || (y % 100 != 0 && y % 4 == 0)))
                abs_day += 1;
            offset = abs_day - days_to_new_year(gdo_pkg::EPOCH_YEAR);
            // Day zero of year zero gives -1, hence the sign fix on the remainder.
            wd = abs_day % DAYS_PER_WEEK;
            if (wd < 0)
                wd += DAYS_PER_WEEK;
            wd = (wd + YEAR_ZERO_WEEKDAY) % DAYS_PER_WEEK;
            r.day_offset = offset[gdo_pkg::OFFSET_W-1:0];
            r.weekday    = wd[gdo_pkg::WDAY_W-1:0];
            return r;
        endfunction

        function void note_date(gdo_pkg::date_t dt);
            awaited.push_back(predict(dt));
            noted++;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void check_result(gdo_pkg::result_t got);
            gdo_pkg::result_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $error("result: no request outstanding, got offset %0d weekday %0d",
                       $signed(got.day_offset), got.weekday);
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (got.day_offset !== want.day_offset)
            begin
                errors++;
                $error("day_offset: expected %0d, got %0d",
                       $signed(want.day_offset), $signed(got.day_offset));
            end
            if (got.weekday !== want.weekday)
            begin
                errors++;
                $error("weekday: expected %0d, got %0d", want.weekday, got.weekday);
            end
        endfunction
    endclass

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             date_valid   = 1'b0;
    logic             date_stall;
    gdo_pkg::date_t   date         = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    gdo_pkg::result_t result;

    // Idle and stall rates in percent, set per phase by the stimulus thread.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    // Raised by the stimulus thread to ask the result side for a long hold-off.
    bit hold_off_go        = 1'b0;

    day_offset_book book = new();

    gregorian_date_to_day_offset u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .date_valid   (date_valid),
        .date_stall   (date_stall),
        .date         (date),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    // Result side. The stall line moves only at falling edges. A hold-off keeps
    // it high while the sender keeps offering requests, so the pipeline fills
    // and pushes back on the date channel.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_off_go)
            begin
                hold_off_go = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            result_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Results are taken at the rising edge, where both handshake lines are
    // stable: the stall line was set at the previous falling edge.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            book.check_result(result);
    end

    // The watchdog restarts whenever either channel moves a request or a result.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (date_valid && !date_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    function automatic gdo_pkg::date_t make_date(input int dd, input int mm, input int yy);
        gdo_pkg::date_t dt;
        dt.day_of_month = gdo_pkg::DAY_W'(dd);
        dt.month_number = gdo_pkg::MONTH_W'(mm);
        dt.year_number  = gdo_pkg::YEAR_W'(yy);
        return dt;
    endfunction

    // Mostly dates with every field in its legal range; the rest are raw bit
    // patterns that reach day zero, month zero and above twelve, and years past
    // the top of the range, so that every field bit toggles.
    function automatic gdo_pkg::date_t random_date();
        logic [31:0]    bits;
        gdo_pkg::date_t dt;
        if ($urandom_range(99) < 80)
        begin
            dt.day_of_month = gdo_pkg::DAY_W'($urandom_range(31, 1));
            dt.month_number = gdo_pkg::MONTH_W'($urandom_range(MONTH_LAST, 1));
            dt.year_number  = gdo_pkg::YEAR_W'($urandom_range(gdo_pkg::YEAR_MAX, 1));
        end
        else
        begin
            bits = $urandom;
            dt   = bits[$bits(gdo_pkg::date_t)-1:0];
        end
        return dt;
    endfunction

    // Offers one request and returns at the falling edge after it is taken.
    // The valid line is left high, so a back-to-back request needs no toggle.
    task automatic send_date(input gdo_pkg::date_t dt);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            date_valid <= 1'b0;
            @(negedge clk);
        end
        date_valid <= 1'b1;
        date       <= dt;
        do
            @(posedge clk);
        while (date_stall);
        book.note_date(dt);
        @(negedge clk);
    endtask

    // Stops offering requests until every outstanding result has come back.
    task automatic drain_results();
        date_valid <= 1'b0;
        while (book.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        gdo_pkg::date_t opening [$];
        int             phase;

        // The epoch and its eve.
        opening.push_back(make_date(1, 1, 1960));
        opening.push_back(make_date(31, 12, 1959));
        // Leap rules: every 400 years, not on plain centuries, and before the
        // epoch too, where February must count 29 days.
        opening.push_back(make_date(29, 2, 2000));
        opening.push_back(make_date(29, 2, 1900));
        opening.push_back(make_date(1, 3, 1900));
        opening.push_back(make_date(29, 2, 1956));
        opening.push_back(make_date(1, 3, 1956));
        opening.push_back(make_date(29, 2, 1600));
        opening.push_back(make_date(1, 3, 2100));
        // Days past the end of the month run on linearly.
        opening.push_back(make_date(31, 2, 2023));
        opening.push_back(make_date(31, 2, 2024));
        opening.push_back(make_date(31, 4, 2021));
        opening.push_back(make_date(0, 3, 1970));
        // Ends of the year range, year zero, and years above the top.
        opening.push_back(make_date(1, 1, 1));
        opening.push_back(make_date(31, 12, 9999));
        opening.push_back(make_date(1, 3, 0));
        opening.push_back(make_date(0, 0, 0));
        opening.push_back(make_date(31, 15, 16383));
        opening.push_back(make_date(15, 6, 10000));
        // Months above twelve fold onto December, month zero onto January.
        opening.push_back(make_date(25, 13, 2020));
        opening.push_back(make_date(1, 14, 1800));
        opening.push_back(make_date(10, 0, 2200));

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening[i])
            send_date(opening[i]);
        drain_results();

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
                default: begin sender_idle_pct = 26; receiver_stall_pct = 26; end
            endcase
            repeat (PHASE_DATES) send_date(random_date());

            // After the first phase, back the pipeline up against a long hold-off
            // with the sender running flat out.
            if (phase == 0)
            begin
                hold_off_go = 1'b1;
                repeat (HOLD_OFF_DATES) send_date(random_date());
            end
        end

        date_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d results for %0d date requests: field extremes, leap rules, day",
                 book.checked, book.noted);
        $display("overflow and month folding, under four idle mixes, a hold-off and a drain.");
        if (book.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
